>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the escaper rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, masked while reset is low
`define JSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same check with no reset mask, for properties that must hold during reset too
`define JSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// types and character constants shared by the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int unsigned MAX_SEQ = 7;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // escaped byte sequence, entry 0 goes out first
    typedef struct packed {
        logic [MAX_SEQ-1:0][7:0] bytes;
        logic [2:0]              cnt;
    } t_seq;

    function automatic logic [7:0] f_hex(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

>>> rtl/core/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// streaming json string quoter: one string byte in, its quoted form out
// usage:
//   s_axis carries one byte of a nul-terminated string per word; a zero byte
//   ends the string. m_axis carries the escaped text one byte per word, with
//   tlast on the final byte produced by each input byte.
//   an opening quote precedes the first byte of every string and a zero byte
//   produces the closing quote.
//   the first output byte is valid once its input word has passed the input
//   register and then been loaded into the result register.
//   throughput: one input word per cycle for bytes that pass through, while
//   m_axis_tready is high; an input byte that expands to n output bytes
//   (n from 1 to 7) holds the one-lane result register until all n are out.
//   a stalled m_axis keeps the result register and the input register full,
//   after which s_axis_tready drops; no word is lost.
//   reset (synchronous, active low) empties both registers and leaves no
//   string open.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);
    import jse_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    // string open flag, advanced as each byte enters the result register
    logic       r_open;

    t_seq seq;
    logic next_open;
    logic seq_ready;
    logic load;

    assign load          = r_in_valid && seq_ready;
    assign s_axis_tready = !r_in_valid || load;

    jse_expand u_expand (
        .i_byte (r_in_byte),
        .i_open (r_open),
        .o_seq  (seq),
        .o_open (next_open)
    );

    jse_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_seq    (seq),
        .o_ready  (seq_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_open     <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_open <= next_open;
            end
        end
    end

    // a loaded sequence shows up on the output next cycle
    `JSE_ASSERT(a_load_shows, i_clk, i_rst_n, load |=> m_axis_tvalid, "load did not raise tvalid")
    // only a zero byte closes the string
    `JSE_ASSERT(a_open_track, i_clk, i_rst_n, load |=> (r_open == ($past(r_in_byte) != CH_NUL)), "string open flag wrong")
    // a waiting input byte is neither dropped nor overwritten
    `JSE_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !load) |=> (r_in_valid && $stable(r_in_byte)), "input register lost its byte")

endmodule

>>> rtl/core/jse_expand.sv
// ----------------------------------------------------------------------------
// jse_expand
// turns one string byte into its quoted and escaped byte sequence
// ----------------------------------------------------------------------------
module jse_expand (
    input  logic [7:0]   i_byte,
    input  logic         i_open,
    output jse_pkg::t_seq o_seq,
    output logic         o_open
);
    import jse_pkg::*;

    logic [5:0][7:0] body;
    logic [2:0]      body_len;

    always_comb begin
        body     = '0;
        body_len = 3'd1;
        o_open   = 1'b1;
        unique case (i_byte) inside
            CH_NUL: begin
                body[0] = CH_QUOTE;
                o_open  = 1'b0;
            end
            CH_BS: begin
                body[0]  = CH_BSLASH;
                body[1]  = CH_LOW_B;
                body_len = 3'd2;
            end
            CH_LF: begin
                body[0]  = CH_BSLASH;
                body[1]  = CH_LOW_N;
                body_len = 3'd2;
            end
            CH_CR: begin
                body[0]  = CH_BSLASH;
                body[1]  = CH_LOW_R;
                body_len = 3'd2;
            end
            CH_TAB: begin
                body[0]  = CH_BSLASH;
                body[1]  = CH_LOW_T;
                body_len = 3'd2;
            end
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                body[0]  = CH_BSLASH;
                body[1]  = i_byte;
                body_len = 3'd2;
            end
            default: begin
                if (i_byte < CH_SPACE) begin
                    // other controls: \u00xx
                    body[0]  = CH_BSLASH;
                    body[1]  = CH_LOW_U;
                    body[2]  = CH_ZERO;
                    body[3]  = CH_ZERO;
                    body[4]  = f_hex(i_byte[7:4]);
                    body[5]  = f_hex(i_byte[3:0]);
                    body_len = 3'd6;
                end else begin
                    body[0] = i_byte;
                end
            end
        endcase
    end

    // opening quote in front when no string is open
    always_comb begin
        if (i_open) begin
            o_seq.bytes = {8'h00, body};
            o_seq.cnt   = body_len;
        end else begin
            o_seq.bytes = {body, CH_QUOTE};
            o_seq.cnt   = body_len + 3'd1;
        end
    end

endmodule

>>> rtl/core/jse_serial.sv
// ----------------------------------------------------------------------------
// jse_serial
// result register that shifts out one escaped byte per word
// ----------------------------------------------------------------------------
module jse_serial (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  jse_pkg::t_seq i_seq,
    output logic          o_ready,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [7:0]    o_tdata,
    output logic          o_tlast
);
    import jse_pkg::*;

    logic [MAX_SEQ-1:0][7:0] r_bytes, n_bytes;
    logic [2:0]              r_rem, n_rem;
    logic                    r_valid, n_valid;

    assign o_ready  = !r_valid || (i_tready && (r_rem == 3'd1));
    assign o_tvalid = r_valid;
    assign o_tdata  = r_bytes[0];
    assign o_tlast  = (r_rem == 3'd1);

    always_comb begin
        n_bytes = r_bytes;
        n_rem   = r_rem;
        n_valid = r_valid;
        if (i_load) begin
            n_bytes = i_seq.bytes;
            n_rem   = i_seq.cnt;
            n_valid = 1'b1;
        end else if (r_valid && i_tready) begin
            n_bytes = {8'h00, r_bytes[MAX_SEQ-1:1]};
            n_rem   = r_rem - 3'd1;
            n_valid = (r_rem != 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rem   <= n_rem;
            r_valid <= n_valid;
        end
    end

endmodule
